@@ rtl/core/plia_pkg.sv @@
// Package for the positional list: sizes, request codes and the control
// word broadcast to every storage cell. No dependencies.
`timescale 1ns / 1ps

package plia_pkg;

  // List sizing
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  // Request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Control word shared by all cells for one request
  typedef struct packed {
    logic                     ins;   // insert at pos, shift later entries up
    logic                     rem;   // remove at pos, shift later entries down
    logic [IDX_W-1:0]         pos;   // list index of the request
    logic signed [DATA_W-1:0] value; // value written on insert
  } cell_ctrl_t;

endpackage

@@ rtl/core/plia_cell.sv @@
// One storage cell of the positional list: holds a single entry and takes
// its neighbor's entry on a shift. Depends on plia_pkg.
`timescale 1ns / 1ps

module plia_cell (
  input  logic                              clk,
  input  plia_pkg::cell_ctrl_t              ctrl,
  input  logic [plia_pkg::IDX_W-1:0]        idx,
  input  logic signed [plia_pkg::DATA_W-1:0] lower_data,
  input  logic signed [plia_pkg::DATA_W-1:0] upper_data,
  output logic signed [plia_pkg::DATA_W-1:0] data,
  output logic signed [plia_pkg::DATA_W-1:0] rd_data
);
  import plia_pkg::*;

  logic above;
  logic here;

  assign above = idx > ctrl.pos;
  assign here  = idx == ctrl.pos;

  // Entry update: shift up, load, shift down or hold
  always_ff @(posedge clk) begin
    if (ctrl.ins && above) begin
      data <= lower_data;
    end else if (ctrl.ins && here) begin
      data <= ctrl.value;
    end else if (ctrl.rem && (above || here)) begin
      data <= upper_data;
    end
  end

  // Read port: drive the entry only when this cell is addressed
  assign rd_data = here ? data : '0;

endmodule

@@ rtl/core/positional_list_insert_remove.sv @@
// Top level of the positional list: request decode, count, row of cells
// and the result register. Depends on plia_pkg and plia_cell.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+------------------------------
//  request | in        | in_valid/in_stall  | req_type, position, value
//  result  | out       | out_valid/out_stall| ok, entry_count, read_value
//
//  Every request is handled at the accepting edge: the whole row of cells
//  shifts, loads or holds there, so one word per cycle is sustained unless the result side stalls.
//  The result appears in the output register the cycle after acceptance.
//  A new request is taken while the output register is empty or drained
//  in the same cycle; a stalled result holds and stalls the request side.
//  Reset clears the count and the output valid; entries are not cleared.

module positional_list_insert_remove (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          req_type,
  input  logic [plia_pkg::POS_W-1:0]          position,
  input  logic signed [plia_pkg::DATA_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic [plia_pkg::POS_W-1:0]          entry_count,
  output logic signed [plia_pkg::DATA_W-1:0]  read_value
);
  import plia_pkg::*;

  logic                     accept;
  logic [CNT_W-1:0]         held_count;
  logic [CNT_W-1:0]         held_count_next;
  logic [POS_W-1:0]         count_w;
  logic                     full;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     rd_ok;
  logic                     req_ok;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
  logic signed [DATA_W-1:0] rd_sel;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Range checks against the current count
  assign count_w = POS_W'(held_count);
  assign full    = held_count == CNT_W'(CAPACITY);
  assign ins_ok  = (req_type == REQ_INSERT) && (position <= count_w) && !full;
  assign rem_ok  = (req_type == REQ_REMOVE) && (position < count_w);
  assign rd_ok   = (req_type == REQ_READ) && (position < count_w);

  always_comb begin
    req_ok = 1'b0;
    unique case (req_type)
      REQ_INSERT: req_ok = ins_ok;
      REQ_REMOVE: req_ok = rem_ok;
      REQ_READ:   req_ok = rd_ok;
      default:    req_ok = 1'b0;
    endcase
  end

  // Broadcast control to the row
  always_comb begin
    ctrl.ins   = accept && ins_ok;
    ctrl.rem   = accept && rem_ok;
    ctrl.pos   = position[IDX_W-1:0];
    ctrl.value = value;
  end

  // Row of cells, each linked to its lower and upper neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    if (g == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[g+1];
    end
    plia_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // Read bus: at most one cell drives a nonzero word
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  // Count update
  always_comb begin
    held_count_next = held_count;
    if (ctrl.ins) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (ctrl.rem) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else begin
      held_count <= held_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok          <= req_ok;
      entry_count <= POS_W'(held_count_next);
      read_value  <= rd_ok ? rd_sel : '0;
    end
  end

endmodule

@@ verif/tb_positional_list_insert_remove.sv @@
// Testbench for positional_list_insert_remove: drives insert, remove and read
// words against a behavioral copy of the list and checks every result word.
// Depends on plia_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_positional_list_insert_remove;
  import plia_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic                     ok;
    logic [POS_W-1:0]         count;
    logic signed [DATA_W-1:0] rd;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               req_type = REQ_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     ok;
  logic [POS_W-1:0]         entry_count;
  logic signed [DATA_W-1:0] read_value;

  // Behavioral copy of the list and the results it predicts
  logic signed [DATA_W-1:0] list_model [CAPACITY];
  int                       model_count = 0;
  list_result_t             pending_results [$];
  list_result_t             want;

  int mismatches = 0;
  int cycle_count = 0;
  int src_idle_pct = 30;
  int sink_idle_pct = 30;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  positional_list_insert_remove uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .entry_count (entry_count),
    .read_value  (read_value)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s got %0h, predicted %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // Apply one accepted request to the list copy and queue its result word
  function automatic void apply_list_request(input logic [1:0] kind, input int pos,
                                             input logic signed [DATA_W-1:0] val);
    list_result_t res;
    res.ok = 1'b0;
    res.rd = '0;
    case (kind)
      REQ_INSERT: begin
        if (pos <= model_count && model_count < CAPACITY) begin
          for (int i = model_count; i > pos; i--) list_model[i] = list_model[i-1];
          list_model[pos] = val;
          model_count++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos < model_count) begin
          for (int i = pos; i + 1 < model_count; i++) list_model[i] = list_model[i+1];
          model_count--;
          res.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (pos < model_count) begin
          res.ok = 1'b1;
          res.rd = list_model[pos];
        end
      end
      default: ;
    endcase
    res.count = model_count[POS_W-1:0];
    pending_results.push_back(res);
  endfunction

  // Offer one request word, wait for acceptance, then predict it.
  // Valid stays high between back-to-back words; it drops only on a gap.
  task automatic send_word(input logic [1:0] kind, input int pos,
                           input logic signed [DATA_W-1:0] val);
    logic [POS_W-1:0] p7;
    p7 = pos[POS_W-1:0];
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      req_type <= 2'($urandom);
      position <= POS_W'($urandom);
      value    <= $urandom;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= p7;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_request(kind, int'(p7), val);
  endtask

  // Receiver: random stall, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Result check against the oldest predicted word
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, entry_count", 32'(entry_count), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
        if (entry_count !== want.count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
        if (read_value !== want.rd) report_mismatch("read_value", read_value, want.rd);
      end
    end
  end

  // Requests on an empty list, including the unused code
  task automatic test_empty_list;
    send_word(REQ_READ, 0, 32'sd0);
    send_word(REQ_REMOVE, 0, 32'sd0);
    send_word(REQ_INSERT, 1, 32'sd5);
    send_word(REQ_UNUSED, 127, -32'sd1);
    send_word(REQ_READ, 127, 32'sd0);
  endtask

  // Inserts at front, middle and end, one past the end, then read back
  task automatic test_insert_positions;
    send_word(REQ_INSERT, 0, VAL_MIN);
    send_word(REQ_INSERT, 1, VAL_MAX);
    send_word(REQ_INSERT, 1, 32'sd0);
    send_word(REQ_INSERT, 0, -32'sd1);
    send_word(REQ_INSERT, 5, 32'sd7);
    send_word(REQ_INSERT, 4, 32'sh5a5a_5a5a);
    for (int i = 0; i <= 5; i++) send_word(REQ_READ, i, 32'sd0);
  endtask

  // Removes from middle, front and end; the freed top slot must not read back
  task automatic test_remove_positions;
    send_word(REQ_REMOVE, 2, 32'sd0);
    send_word(REQ_REMOVE, 0, 32'sd0);
    send_word(REQ_REMOVE, 2, 32'sd0);
    send_word(REQ_REMOVE, 3, 32'sd0);
    send_word(REQ_READ, 0, 32'sd0);
    send_word(REQ_READ, 1, 32'sd0);
    send_word(REQ_READ, 2, 32'sd0);
  endtask

  // Random words: mostly in-range positions, some noise across the full field
  task automatic test_random_traffic(input int n, input int ins_pct, input int rem_pct,
                                     input int rd_pct);
    int r;
    int pos;
    logic [1:0] kind;
    logic signed [DATA_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < ins_pct) kind = REQ_INSERT;
      else if (r < ins_pct + rem_pct) kind = REQ_REMOVE;
      else if (r < ins_pct + rem_pct + rd_pct) kind = REQ_READ;
      else kind = REQ_UNUSED;
      if ($urandom_range(99) < 12) pos = $urandom_range(127);
      else if (kind == REQ_INSERT) pos = $urandom_range(model_count);
      else pos = (model_count > 0) ? $urandom_range(model_count - 1) : 0;
      case ($urandom_range(9))
        0: val = VAL_MIN;
        1: val = VAL_MAX;
        2: val = 32'sd0;
        3: val = -32'sd1;
        default: val = $urandom;
      endcase
      send_word(kind, pos, val);
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_receiver_holdoff;
    hold_req++;
    test_random_traffic(150, 40, 30, 28);
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_full_rate;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(300, 40, 30, 28);
    src_idle_pct = 30;
    sink_idle_pct = 30;
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_insert_positions();
    test_remove_positions();
    // fill until inserts hit the full list, then churn and drain
    test_random_traffic(250, 70, 10, 18);
    test_full_rate();
    test_receiver_holdoff();
    test_random_traffic(250, 15, 65, 18);
    test_random_traffic(150, 40, 30, 28);

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("result words never arrived", pending_results.size(), 32'd0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
